>>> sv/srm_pkg.sv
// shared types and codes for the selective receive mailbox
package srm_pkg;

    typedef enum logic [1:0] {
        ACT_SEND  = 2'd0,
        ACT_RECV  = 2'd1,
        ACT_JOIN  = 2'd2,
        ACT_LEAVE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LONG  = 3'd1,
        ST_NOT_MEMB  = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NO_MATCH  = 3'd4,
        ST_ABANDON   = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_WRITE,
        S_RD,
        S_RDWAIT,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WAIT,
        S_SHIFT_WR,
        S_FINISH,
        S_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic decide;
        logic send_write;
        logic rd_cur;
        logic check_cur;
        logic rd_next;
        logic shift_wr;
        logic finish;
        logic out_load;
    } srm_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic early_done;
        logic is_send;
        logic is_recv;
        logic found;
        logic search_over;
        logic shift_done;
    } srm_sts_t;

endpackage

>>> sv/srm_ctrl.sv
// controller state machine of the mailbox
module srm_ctrl
    import srm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  srm_sts_t sts,
    output srm_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign s_tready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                if (sts.early_done) begin
                    state_next = S_OUT;
                end else if (sts.is_send) begin
                    state_next = S_WRITE;
                end else if (sts.is_recv) begin
                    state_next = S_RD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_WRITE: begin
                cmd.send_write = 1'b1;
                state_next     = S_OUT;
            end
            S_RD: begin
                cmd.rd_cur = 1'b1;
                state_next = S_RDWAIT;
            end
            S_RDWAIT: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                cmd.check_cur = 1'b1;
                if (sts.found) begin
                    state_next = S_SHIFT_RD;
                end else if (sts.search_over) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_RD;
                end
            end
            S_SHIFT_RD: begin
                if (sts.shift_done) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHIFT_WAIT;
                end
            end
            S_SHIFT_WAIT: begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> sv/srm_dpath.sv
// datapath: channel tables, message memory, search and compaction
module srm_dpath
    import srm_pkg::*;
#(
    parameter int NUM_MEMBERS   = 16,
    parameter int POOL_DEPTH    = 16,
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  srm_cmd_t    cmd,
    output srm_sts_t    sts,
    input  logic [1:0]  in_action,
    input  logic [3:0]  in_channel,
    input  logic [3:0]  in_sender,
    input  logic        in_any,
    input  logic [3:0]  in_length,
    input  logic [63:0] in_payload,
    input  logic [7:0]  in_size,
    output logic [2:0]  out_status,
    output logic [3:0]  out_length,
    output logic [63:0] out_data,
    output logic [3:0]  out_from
);

    localparam int SW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW  = $clog2(POOL_DEPTH + 1);
    localparam int MW  = (NUM_MEMBERS > 1) ? $clog2(NUM_MEMBERS) : 1;
    localparam int TW  = $clog2(NUM_MEMBERS + 1);
    localparam int AW  = MW + SW;
    localparam int DEP = NUM_MEMBERS * POOL_DEPTH;
    localparam int PBW = 4;
    localparam int CHW = (MW + 1 > 5) ? MW + 1 : 5;

    // per channel state
    logic [NUM_MEMBERS-1:0] joined_reg;
    logic [SW-1:0]          newest_reg [NUM_MEMBERS];
    logic [CW-1:0]          count_reg  [NUM_MEMBERS];
    logic [TW-1:0]          total_reg;

    // message memory: payload, sender, size
    logic [75:0] mem [DEP];
    logic [75:0] rd_reg;

    // latched transaction
    logic [1:0]     act_reg;
    logic [CHW-1:0] ch_reg;
    logic [3:0]     sid_reg;
    logic           any_reg;
    logic [3:0]     len_reg;
    logic [63:0]    pay_reg;
    logic [7:0]     dsz_reg;

    // working registers
    logic [SW-1:0] p_reg;
    logic [SW-1:0] nw_reg;
    logic [CW-1:0] n_reg;
    logic [75:0]   hit_reg;
    logic [2:0]    st_reg;
    logic [2:0]    ost_reg;
    logic [3:0]    olen_reg;
    logic [63:0]   odata_reg;
    logic [3:0]    ofrom_reg;

    logic          valid_ch, member;
    logic [MW-1:0] chi;
    logic [SW-1:0] cur_newest, slot_nx, slot_pv, p_nx;
    logic [CW-1:0] cur_count;
    logic          too_long;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [75:0]   wr_data;
    logic          wr_en, rd_en;
    logic [63:0]   send_mask, recv_mask;

    function automatic logic [63:0] mask_of(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int k = 0; k < 8; k++) begin
            if (4'(k) < n) m[8*k +: 8] = 8'hff;
        end
        return m;
    endfunction

    function automatic logic [63:0] in_payload_mask();
        return pay_reg & send_mask;
    endfunction

    assign valid_ch   = (ch_reg < CHW'(NUM_MEMBERS));
    assign chi        = ch_reg[MW-1:0];
    assign member     = valid_ch && joined_reg[chi];
    assign cur_newest = newest_reg[chi];
    assign cur_count  = count_reg[chi];
    assign too_long   = (len_reg > PBW'(PAYLOAD_BYTES));
    assign slot_nx    = (cur_newest >= SW'(POOL_DEPTH - 1)) ? '0 : cur_newest + 1'b1;
    assign slot_pv    = (cur_newest == '0) ? SW'(POOL_DEPTH - 1) : cur_newest - 1'b1;
    assign p_nx       = (p_reg >= SW'(POOL_DEPTH - 1)) ? '0 : p_reg + 1'b1;
    assign send_mask  = mask_of(len_reg);
    assign recv_mask  = send_mask;

    // early exit decode and search status
    always_comb begin
        sts             = '0;
        sts.is_send     = (act_reg == ACT_SEND);
        sts.is_recv     = (act_reg == ACT_RECV);
        sts.early_done  = 1'b0;
        if ((act_reg == ACT_SEND || act_reg == ACT_RECV) && (too_long || !member)) begin
            sts.early_done = 1'b1;
        end
        if (act_reg == ACT_RECV && cur_count == '0) sts.early_done = 1'b1;
        sts.found       = any_reg || (rd_reg[67:64] == sid_reg);
        sts.search_over = (n_reg <= CW'(1));
        sts.shift_done  = (p_reg == nw_reg);
    end

    // memory port control
    always_comb begin
        rd_en   = cmd.rd_cur || cmd.rd_next;
        rd_addr = {chi, (cmd.rd_next ? p_nx : p_reg)};
        wr_en   = cmd.send_write || cmd.shift_wr;
        wr_addr = cmd.send_write ? {chi, slot_nx} : {chi, p_reg};
        wr_data = cmd.send_write ? {dsz_reg, sid_reg, in_payload_mask()} : rd_reg;
    end

    // message memory
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_reg <= mem[rd_addr];
    end

    // transaction, working and output registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg <= in_action;
            ch_reg  <= CHW'(in_channel);
            sid_reg <= in_sender;
            any_reg <= in_any;
            len_reg <= in_length;
            pay_reg <= in_payload;
            dsz_reg <= in_size;
        end
        if (cmd.decide) begin
            p_reg     <= cur_newest;
            nw_reg    <= cur_newest;
            n_reg     <= cur_count;
            st_reg    <= ST_OK;
            if ((act_reg == ACT_SEND || act_reg == ACT_RECV) && too_long) begin
                st_reg <= ST_TOO_LONG;
            end else if ((act_reg == ACT_SEND || act_reg == ACT_RECV) && !member) begin
                st_reg <= ST_NOT_MEMB;
            end else if (act_reg == ACT_RECV && cur_count == '0) begin
                st_reg <= ST_EMPTY;
            end else if (act_reg == ACT_JOIN && !valid_ch) begin
                st_reg <= ST_NOT_MEMB;
            end else if (act_reg == ACT_JOIN && total_reg >= TW'(NUM_MEMBERS)) begin
                st_reg <= ST_FULL;
            end else if (act_reg == ACT_LEAVE && !member) begin
                st_reg <= ST_NOT_MEMB;
            end
        end
        if (cmd.check_cur) begin
            if (sts.found) begin
                hit_reg   <= rd_reg;
            end else begin
                n_reg <= n_reg - 1'b1;
                p_reg <= (p_reg == '0) ? SW'(POOL_DEPTH - 1) : p_reg - 1'b1;
                if (sts.search_over) st_reg <= ST_NO_MATCH;
            end
        end
        if (cmd.shift_wr) p_reg <= p_nx;
        if (cmd.out_load) begin
            ost_reg   <= st_reg;
            olen_reg  <= '0;
            odata_reg <= '0;
            ofrom_reg <= '0;
            if (st_reg == ST_OK && act_reg == ACT_SEND) olen_reg <= len_reg;
            if (st_reg == ST_OK && act_reg == ACT_RECV) begin
                if (hit_reg[75:68] > {4'd0, len_reg}) begin
                    ost_reg <= ST_ABANDON;
                end else begin
                    olen_reg  <= len_reg;
                    odata_reg <= hit_reg[63:0] & recv_mask;
                    ofrom_reg <= hit_reg[67:64];
                end
            end
        end
    end

    // channel table updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            joined_reg <= '0;
            total_reg  <= '0;
            for (int i = 0; i < NUM_MEMBERS; i++) begin
                newest_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
        end else begin
            if (cmd.send_write) begin
                newest_reg[chi] <= slot_nx;
                if (cur_count < CW'(POOL_DEPTH)) count_reg[chi] <= cur_count + 1'b1;
            end
            if (cmd.finish) begin
                newest_reg[chi] <= slot_pv;
                count_reg[chi]  <= cur_count - 1'b1;
            end
            if (cmd.decide && act_reg == ACT_JOIN && valid_ch
                && total_reg < TW'(NUM_MEMBERS) && !joined_reg[chi]) begin
                joined_reg[chi] <= 1'b1;
                newest_reg[chi] <= '0;
                count_reg[chi]  <= '0;
                total_reg       <= total_reg + 1'b1;
            end
            if (cmd.decide && act_reg == ACT_LEAVE && member) begin
                joined_reg[chi] <= 1'b0;
                newest_reg[chi] <= '0;
                count_reg[chi]  <= '0;
                if (total_reg != '0) total_reg <= total_reg - 1'b1;
            end
        end
    end

    assign out_status = ost_reg;
    assign out_length = olen_reg;
    assign out_data   = odata_reg;
    assign out_from   = ofrom_reg;

endmodule

>>> sv/selective_receive_mailbox_core.sv
// top level of the selective receive mailbox
//  channel | dir | tdata fields (low bit up)
//  s_      | in  | action, channel_id, src_id, any_sender, length, payload, declared_size
//  m_      | out | status, result_length, data_out, from_id
// one transaction at a time
// a receive searches the slots newest first, then moves the newer entries
// back one slot through the single message memory read port
// aresetn is synchronous; channel tables clear at once, no clearing pass
// a stalled result holds in the output register; the next transaction
// runs and waits in its output state until that result moves
module selective_receive_mailbox_core
    import srm_pkg::*;
#(
    parameter int NUM_MEMBERS   = 16,
    parameter int POOL_DEPTH    = 16,
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0] channel_id[5:2] src_id[9:6] any_sender[10] length[14:11]
    // payload[78:15] declared_size[86:79], zero fill to 88
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0] result_length[6:3] data_out[70:7] from_id[74:71], zero fill to 80
    output logic [79:0] m_tdata
);

    srm_cmd_t    cmd;
    srm_sts_t    sts;
    logic [2:0]  o_st;
    logic [3:0]  o_len;
    logic [63:0] o_data;
    logic [3:0]  o_from;

    srm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    srm_dpath #(
        .NUM_MEMBERS   (NUM_MEMBERS),
        .POOL_DEPTH    (POOL_DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_action  (s_tdata[1:0]),
        .in_channel (s_tdata[5:2]),
        .in_sender  (s_tdata[9:6]),
        .in_any     (s_tdata[10]),
        .in_length  (s_tdata[14:11]),
        .in_payload (s_tdata[78:15]),
        .in_size    (s_tdata[86:79]),
        .out_status (o_st),
        .out_length (o_len),
        .out_data   (o_data),
        .out_from   (o_from)
    );

    assign m_tdata = {5'd0, o_from, o_data, o_len, o_st};

endmodule

>>> sv/srm_checker.sv
// port level checks of the mailbox core and their binding
module srm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    // a stalled result keeps its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // no new transaction taken in the cycle after one was accepted
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // status code stays in range
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] != 3'd7)
        else $error("bad status code");

    // failed results carry zero length
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != 3'd0 |-> m_tdata[6:3] == 4'd0)
        else $error("failure with nonzero length");

endmodule

bind selective_receive_mailbox_core srm_checker u_srm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
